[design/sinfo_pkg.sv]
`timescale 1ns / 1ps

package sinfo_pkg;

  // where the parser is within the message
  typedef enum logic [2:0] {
    PH_HEADER      = 3'd0,
    PH_NODE_COUNT  = 3'd1,
    PH_NODE_LEN    = 3'd2,
    PH_NODE_DATA   = 3'd3,
    PH_CODEC_COUNT = 3'd4,
    PH_CODEC_LEN   = 3'd5,
    PH_CODEC_DATA  = 3'd6,
    PH_DONE        = 3'd7
  } phase_t;

  localparam logic [2:0] HEADER_BYTES = 3'd6;
  localparam logic [2:0] CLIENT_HI_IDX = 3'd4;
  localparam logic [2:0] CLIENT_LO_IDX = 3'd5;
  localparam logic [2:0] NAME_LEN = 3'd4;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  localparam logic [7:0] OPUS_NAME [4] = '{8'h4f, 8'h50, 8'h55, 8'h53};

  typedef struct packed {
    logic        status;
    logic [15:0] client_id;
    logic [15:0] node_count;
    logic        opus_offered;
  } result_t;

  // ascii lower case to upper case, other bytes unchanged
  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] up;
    begin
      if (b >= 8'h61 && b <= 8'h7a) begin
        up = b - CASE_OFFSET;
      end else begin
        up = b;
      end
      return up;
    end
  endfunction

endpackage

[design/sinfo_in_if.sv]
`timescale 1ns / 1ps

interface sinfo_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[design/sinfo_out_if.sv]
`timescale 1ns / 1ps

interface sinfo_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] client_id;
  logic [15:0] node_count;
  logic        opus_offered;

  modport source (output valid, output status, output client_id, output node_count,
                  output opus_offered, input ready);
  modport sink (input valid, input status, input client_id, input node_count,
                input opus_offered, output ready);
endinterface

[design/sinfo_parse.sv]
`timescale 1ns / 1ps

module sinfo_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output sinfo_pkg::result_t result
);
  import sinfo_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  hdr_idx, hdr_idx_next;
  logic [7:0]  cnt_hi, cnt_hi_next;
  logic        half_seen, half_seen_next;
  logic [15:0] strings_left, strings_left_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] client_val, client_val_next;
  logic [15:0] node_total, node_total_next;
  logic        nodes_done, nodes_done_next;
  logic [2:0]  match_pos, match_pos_next;
  logic        match_alive, match_alive_next;
  logic        zero_seen, zero_seen_next;
  logic        opus_found, opus_found_next;

  logic [15:0] half_val;
  logic [15:0] strings_dec;
  logic [15:0] bytes_dec;
  logic [2:0]  hdr_inc;
  logic        m_alive;
  logic [2:0]  m_pos;
  logic        m_zero;

  assign half_val    = {cnt_hi, data_byte};
  assign strings_dec = strings_left - 16'd1;
  assign bytes_dec   = bytes_left - 16'd1;
  assign hdr_inc     = hdr_idx + 3'd1;

  // one codec byte through the name matcher
  always_comb begin
    m_alive = match_alive;
    m_pos   = match_pos;
    m_zero  = zero_seen;
    if (!zero_seen && match_alive) begin
      if (data_byte == 8'h00) begin
        m_zero = 1'b1;
        if (match_pos != NAME_LEN) begin
          m_alive = 1'b0;
        end
      end else if (match_pos >= NAME_LEN) begin
        m_alive = 1'b0;
      end else begin
        if (to_upper(data_byte) != OPUS_NAME[match_pos[1:0]]) begin
          m_alive = 1'b0;
        end
        m_pos = match_pos + 3'd1;
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    hdr_idx_next      = hdr_idx;
    cnt_hi_next       = cnt_hi;
    half_seen_next    = half_seen;
    strings_left_next = strings_left;
    bytes_left_next   = bytes_left;
    client_val_next   = client_val;
    node_total_next   = node_total;
    nodes_done_next   = nodes_done;
    match_pos_next    = match_pos;
    match_alive_next  = match_alive;
    zero_seen_next    = zero_seen;
    opus_found_next   = opus_found;

    unique case (phase)
      PH_HEADER: begin
        if (hdr_idx == CLIENT_HI_IDX) begin
          client_val_next = {data_byte, 8'h00};
        end else if (hdr_idx == CLIENT_LO_IDX) begin
          client_val_next = client_val | {8'h00, data_byte};
        end
        hdr_idx_next = hdr_inc;
        if (hdr_inc >= HEADER_BYTES) begin
          phase_next = PH_NODE_COUNT;
        end
      end
      PH_NODE_COUNT: begin
        half_seen_next = !half_seen;
        if (!half_seen) begin
          cnt_hi_next = data_byte;
        end else begin
          node_total_next   = half_val;
          strings_left_next = half_val;
          if (half_val == 16'd0) begin
            nodes_done_next = 1'b1;
            phase_next      = PH_CODEC_COUNT;
          end else begin
            phase_next = PH_NODE_LEN;
          end
        end
      end
      PH_NODE_LEN: begin
        half_seen_next = !half_seen;
        if (!half_seen) begin
          cnt_hi_next = data_byte;
        end else begin
          bytes_left_next = half_val;
          if (half_val == 16'd0) begin
            strings_left_next = strings_dec;
            if (strings_dec == 16'd0) begin
              nodes_done_next = 1'b1;
              phase_next      = PH_CODEC_COUNT;
            end else begin
              phase_next = PH_NODE_LEN;
            end
          end else begin
            phase_next = PH_NODE_DATA;
          end
        end
      end
      PH_NODE_DATA: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == 16'd0) begin
          strings_left_next = strings_dec;
          if (strings_dec == 16'd0) begin
            nodes_done_next = 1'b1;
            phase_next      = PH_CODEC_COUNT;
          end else begin
            phase_next = PH_NODE_LEN;
          end
        end
      end
      PH_CODEC_COUNT: begin
        half_seen_next = !half_seen;
        if (!half_seen) begin
          cnt_hi_next = data_byte;
        end else begin
          strings_left_next = half_val;
          phase_next = (half_val == 16'd0) ? PH_DONE : PH_CODEC_LEN;
        end
      end
      PH_CODEC_LEN: begin
        half_seen_next = !half_seen;
        if (!half_seen) begin
          cnt_hi_next = data_byte;
        end else begin
          bytes_left_next  = half_val;
          match_pos_next   = 3'd0;
          match_alive_next = 1'b1;
          zero_seen_next   = 1'b0;
          if (half_val == 16'd0) begin
            // empty name never matches
            strings_left_next = strings_dec;
            phase_next = (strings_dec == 16'd0) ? PH_DONE : PH_CODEC_LEN;
          end else begin
            phase_next = PH_CODEC_DATA;
          end
        end
      end
      PH_CODEC_DATA: begin
        match_pos_next   = m_pos;
        match_alive_next = m_alive;
        zero_seen_next   = m_zero;
        bytes_left_next  = bytes_dec;
        if (bytes_dec == 16'd0) begin
          if (m_alive && m_pos >= NAME_LEN) begin
            opus_found_next = 1'b1;
          end
          strings_left_next = strings_dec;
          phase_next = (strings_dec == 16'd0) ? PH_DONE : PH_CODEC_LEN;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.status       = (hdr_idx_next < HEADER_BYTES);
    result.client_id    = result.status ? 16'd0 : client_val_next;
    result.node_count   = (result.status || !nodes_done_next) ? 16'd0 : node_total_next;
    result.opus_offered = !result.status && opus_found_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase        <= PH_HEADER;
      hdr_idx      <= 3'd0;
      cnt_hi       <= 8'd0;
      half_seen    <= 1'b0;
      strings_left <= 16'd0;
      bytes_left   <= 16'd0;
      client_val   <= 16'd0;
      node_total   <= 16'd0;
      nodes_done   <= 1'b0;
      match_pos    <= 3'd0;
      match_alive  <= 1'b1;
      zero_seen    <= 1'b0;
      opus_found   <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      hdr_idx      <= hdr_idx_next;
      cnt_hi       <= cnt_hi_next;
      half_seen    <= half_seen_next;
      strings_left <= strings_left_next;
      bytes_left   <= bytes_left_next;
      client_val   <= client_val_next;
      node_total   <= node_total_next;
      nodes_done   <= nodes_done_next;
      match_pos    <= match_pos_next;
      match_alive  <= match_alive_next;
      zero_seen    <= zero_seen_next;
      opus_found   <= opus_found_next;
    end
  end

endmodule

[design/server_info_message_parser_core.sv]
`timescale 1ns / 1ps

// server-info message parser: takes a message one byte per beat on msg, the final
// byte flagged by last_byte, and gives one result beat on res for each message.
// a byte is taken per ready cycle; the result appears the cycle after the last byte
// is accepted, held in a single output register. msg stalls only while that
// register holds a result the sink has not yet taken. status 1 means fewer than
// six bytes (all other fields then read 0); node_count is 0 unless every node
// string arrived complete; opus_offered flags a complete codec name equal to
// opus in any case, the name being cut at its first zero byte. truncated tails
// and trailing bytes are ignored, and the parser is back at its start state for
// the next message straight after the last byte.

module server_info_message_parser_core (
  input  logic  clk,
  input  logic  rst,
  sinfo_in_if.sink    msg,
  sinfo_out_if.source res
);
  import sinfo_pkg::*;

  logic    take;
  result_t result;
  logic    res_valid;
  result_t res_data;

  // the output register frees in the same cycle the sink takes its beat
  assign msg.ready = !res_valid || res.ready;
  assign take      = msg.valid && msg.ready;

  // per-byte state and the combinational update
  sinfo_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (msg.data_byte),
    .last_byte (msg.last_byte),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && msg.last_byte) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && msg.last_byte) begin
      res_data <= result;
    end
  end

  assign res.valid        = res_valid;
  assign res.status       = res_data.status;
  assign res.client_id    = res_data.client_id;
  assign res.node_count   = res_data.node_count;
  assign res.opus_offered = res_data.opus_offered;

  // a short message reports nothing but its status
  a_short_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status |->
      res_data.client_id == 16'd0 && res_data.node_count == 16'd0 && !res_data.opus_offered)
    else $error("short message result carries non-zero fields");

  // every final byte taken leads to a result beat next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    take && msg.last_byte |=> res_valid)
    else $error("final byte accepted without a result");

  // a byte that is not final never creates a result on an empty register
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !res_valid && !(take && msg.last_byte) |=> !res_valid)
    else $error("result appeared without a final byte");

endmodule

[verif/sinfo_scoreboard_pkg.sv]
`timescale 1ns / 1ps

package sinfo_scoreboard_pkg;
  import sinfo_pkg::*;

  class sinfo_scoreboard;
    // parser state mirrored beat by beat
    phase_t      phase;
    logic [2:0]  hdr_idx;
    logic [7:0]  count_hi;
    bit          half_seen;
    logic [15:0] strings_left;
    logic [15:0] bytes_left;
    logic [15:0] client_val;
    logic [15:0] node_total;
    bit          nodes_done;
    logic [2:0]  match_pos;
    bit          match_ok;
    bit          nul_seen;
    bit          opus_hit;

    result_t predicted_results[$];
    int      mismatch_count;

    function new();
      mismatch_count = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = PH_HEADER;
      hdr_idx = '0;
      count_hi = '0;
      half_seen = 0;
      strings_left = '0;
      bytes_left = '0;
      client_val = '0;
      node_total = '0;
      nodes_done = 0;
      match_pos = '0;
      match_ok = 1;
      nul_seen = 0;
      opus_hit = 0;
    endfunction

    // big-endian 16-bit value over two beats, 1 once complete
    function bit take_half(input logic [7:0] b, output logic [15:0] v);
      v = '0;
      if (!half_seen) begin
        count_hi = b;
        half_seen = 1;
        return 0;
      end
      half_seen = 0;
      v = {count_hi, b};
      return 1;
    endfunction

    function void node_done();
      strings_left = strings_left - 16'd1;
      if (strings_left == 16'd0) begin
        nodes_done = 1;
        phase = PH_CODEC_COUNT;
      end else begin
        phase = PH_NODE_LEN;
      end
    endfunction

    function void codec_done();
      if (match_ok && match_pos >= NAME_LEN) opus_hit = 1;
      strings_left = strings_left - 16'd1;
      phase = (strings_left == 16'd0) ? PH_DONE : PH_CODEC_LEN;
    endfunction

    function void note_byte(input logic [7:0] b, input logic is_last);
      logic [15:0] v;
      logic [7:0]  up;
      result_t     r;
      case (phase)
        PH_HEADER: begin
          if (hdr_idx == CLIENT_HI_IDX) client_val = {b, 8'h00};
          else if (hdr_idx == CLIENT_LO_IDX) client_val[7:0] = b;
          hdr_idx = hdr_idx + 3'd1;
          if (hdr_idx >= HEADER_BYTES) phase = PH_NODE_COUNT;
        end
        PH_NODE_COUNT: begin
          if (take_half(b, v)) begin
            node_total = v;
            strings_left = v;
            if (v == 16'd0) begin
              nodes_done = 1;
              phase = PH_CODEC_COUNT;
            end else begin
              phase = PH_NODE_LEN;
            end
          end
        end
        PH_NODE_LEN: begin
          if (take_half(b, v)) begin
            bytes_left = v;
            if (v == 16'd0) node_done();
            else phase = PH_NODE_DATA;
          end
        end
        PH_NODE_DATA: begin
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) node_done();
        end
        PH_CODEC_COUNT: begin
          if (take_half(b, v)) begin
            strings_left = v;
            phase = (v == 16'd0) ? PH_DONE : PH_CODEC_LEN;
          end
        end
        PH_CODEC_LEN: begin
          if (take_half(b, v)) begin
            bytes_left = v;
            match_pos = '0;
            match_ok = 1;
            nul_seen = 0;
            if (v == 16'd0) codec_done();
            else phase = PH_CODEC_DATA;
          end
        end
        PH_CODEC_DATA: begin
          if (!nul_seen && match_ok) begin
            if (b == 8'h00) begin
              nul_seen = 1;
              if (match_pos != NAME_LEN) match_ok = 0;
            end else if (match_pos >= NAME_LEN) begin
              match_ok = 0;
            end else begin
              up = (b >= 8'h61 && b <= 8'h7a) ? b - 8'h20 : b;
              if (up != OPUS_NAME[match_pos[1:0]]) match_ok = 0;
              match_pos = match_pos + 3'd1;
            end
          end
          bytes_left = bytes_left - 16'd1;
          if (bytes_left == 16'd0) codec_done();
        end
        default: ;
      endcase

      if (is_last) begin
        if (hdr_idx < HEADER_BYTES) begin
          r = '{status: 1'b1, client_id: 16'd0, node_count: 16'd0, opus_offered: 1'b0};
        end else begin
          r.status = 1'b0;
          r.client_id = client_val;
          r.node_count = nodes_done ? node_total : 16'd0;
          r.opus_offered = opus_hit;
        end
        predicted_results.push_back(r);
        clear_parse();
      end
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (predicted_results.size() == 0) begin
        $error("result beat with none expected: status %0d client_id %0h node_count %0d",
               got.status, got.client_id, got.node_count);
        mismatch_count++;
        return;
      end
      want = predicted_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatch_count++;
      end
      if (got.client_id !== want.client_id) begin
        $error("client_id: expected %0h, got %0h", want.client_id, got.client_id);
        mismatch_count++;
      end
      if (got.node_count !== want.node_count) begin
        $error("node_count: expected %0d, got %0d", want.node_count, got.node_count);
        mismatch_count++;
      end
      if (got.opus_offered !== want.opus_offered) begin
        $error("opus_offered: expected %0d, got %0d", want.opus_offered, got.opus_offered);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction
  endclass

endpackage

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import sinfo_pkg::*;
  import sinfo_scoreboard_pkg::*;

  logic clk;
  logic rst;

  sinfo_in_if  msg_if ();
  sinfo_out_if res_if ();

  server_info_message_parser_core u_top (
    .clk (clk),
    .rst (rst),
    .msg (msg_if),
    .res (res_if)
  );

  sinfo_scoreboard sb = new();

  // message under construction, sent beat by beat
  logic [7:0] msg_bytes[$];
  int         bytes_sent = 0;
  int         msgs_sent = 0;
  bit         quiet_msg = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back-to-back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic push16(input logic [15:0] v);
    msg_bytes.push_back(v[15:8]);
    msg_bytes.push_back(v[7:0]);
  endtask

  // one codec name string: exact matches in mixed case, names cut by a zero
  // byte, prefixes, overlong and corrupted names, and plain junk
  task automatic push_codec();
    logic [7:0] s[$];
    logic [7:0] c;
    logic [7:0] pool[12];
    int sel;
    int n;
    pool = '{8'h4f, 8'h6f, 8'h50, 8'h70, 8'h55, 8'h75, 8'h53, 8'h73,
             8'h60, 8'h7b, 8'h00, 8'h2f};
    sel = $urandom_range(0, 7);
    case (sel)
      0, 1, 3, 5: begin
        for (int i = 0; i < 4; i++) begin
          c = OPUS_NAME[i];
          if ($urandom_range(0, 1)) c = c + 8'h20;
          s.push_back(c);
        end
        // zero byte ends the name, junk after it still counted
        if (sel == 1) begin
          s.push_back(8'h00);
          repeat ($urandom_range(0, 2)) s.push_back(8'($urandom));
        end
        if (sel == 3) s.push_back(pool[$urandom_range(0, 11)]);
        if (sel == 5) s[$urandom_range(0, 3)] = pool[$urandom_range(8, 11)];
      end
      2: begin
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) s.push_back(OPUS_NAME[i]);
      end
      4: begin
        repeat ($urandom_range(1, 6)) s.push_back(8'($urandom));
      end
      6: begin
        s.push_back(8'h00);
        for (int i = 0; i < 4; i++) s.push_back(OPUS_NAME[i]);
      end
      default: begin
        repeat ($urandom_range(1, 6)) s.push_back(pool[$urandom_range(0, 11)]);
      end
    endcase
    push16(16'(s.size()));
    foreach (s[i]) msg_bytes.push_back(s[i]);
  endtask

  // random message: short and noise messages, otherwise a well-formed body
  // with random content, sometimes cut off early or padded with trailing bytes
  task automatic build_message();
    int kind;
    int r;
    int cut;
    logic [15:0] ncount;
    logic [15:0] ccount;
    int len;
    msg_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 5)) msg_bytes.push_back(8'($urandom));
    end else if (kind < 16) begin
      repeat ($urandom_range(1, 24)) msg_bytes.push_back(8'($urandom));
    end else begin
      repeat (4) msg_bytes.push_back(8'($urandom));
      r = $urandom_range(0, 9);
      push16(r == 0 ? 16'h0000 : (r == 1 ? 16'hffff : 16'($urandom)));
      ncount = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      push16(ncount);
      for (int i = 0; i < ncount && i < 3; i++) begin
        len = $urandom_range(0, 4);
        push16(16'(len));
        repeat (len) msg_bytes.push_back(8'($urandom));
      end
      ccount = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      push16(ccount);
      for (int i = 0; i < ccount && i < 4; i++) push_codec();
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // drive one message, last_byte on its final beat; valid stays high
  // between beats unless a gap is taken
  task automatic send_message();
    int gap;
    bit is_last;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      is_last = (i == msg_bytes.size() - 1);
      gap = quiet_msg ? 0 : pick_gap();
      if (gap > 0) begin
        msg_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      msg_if.valid     <= 1'b1;
      msg_if.data_byte <= msg_bytes[i];
      msg_if.last_byte <= is_last;
      @(posedge clk);
      while (!msg_if.ready) @(posedge clk);
      sb.note_byte(msg_bytes[i], is_last);
      bytes_sent++;
    end
    msgs_sent++;
  endtask

  // stop sending and let every outstanding result beat come back
  task automatic hold_until_drained();
    msg_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // main stimulus
  initial begin
    rst              <= 1'b1;
    msg_if.valid     <= 1'b0;
    msg_if.data_byte <= 8'h00;
    msg_if.last_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // single byte message, all ones: too short
    msg_bytes.delete();
    msg_bytes.push_back(8'hff);
    send_message();

    // header alone, all ones: client id 16'hffff, node list never started
    msg_bytes.delete();
    repeat (6) msg_bytes.push_back(8'hff);
    send_message();

    // all-zero header, empty node list, one mixed-case opus codec
    msg_bytes.delete();
    repeat (6) msg_bytes.push_back(8'h00);
    push16(16'd0);
    push16(16'd1);
    push16(16'd4);
    msg_bytes.push_back(8'h6f);
    msg_bytes.push_back(8'h50);
    msg_bytes.push_back(8'h75);
    msg_bytes.push_back(8'h53);
    send_message();

    // random part; every so often the sender waits for the results to drain
    while (bytes_sent < 750) begin
      quiet_msg = ($urandom_range(0, 3) == 0);
      build_message();
      send_message();
      if (msgs_sent == 20 || $urandom_range(0, 15) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result sink: ready held in runs, long ready stretches and the odd long stall
  initial begin
    int run;
    bit rdy;
    run = 0;
    rdy = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        rdy = ($urandom_range(0, 9) < 7);
        if (rdy) run = $urandom_range(1, 30);
        else if ($urandom_range(0, 9) == 0) run = $urandom_range(10, 40);
        else run = $urandom_range(1, 3);
      end
      run--;
      res_if.ready <= rdy;
    end
  end

  // result monitor: sampled at the edge, before this edge's updates land
  always @(posedge clk) begin
    result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.status       = res_if.status;
      got.client_id    = res_if.client_id;
      got.node_count   = res_if.node_count;
      got.opus_offered = res_if.opus_offered;
      sb.check_result(got);
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
design/sinfo_pkg.sv
design/sinfo_in_if.sv
design/sinfo_out_if.sv
design/sinfo_parse.sv
design/server_info_message_parser_core.sv
verif/sinfo_scoreboard_pkg.sv
verif/tb_top.sv
